// ===== design/ntfs_runlist_decoder_unit_macros.svh =====
// Assertion macros shared by the checker file.
`ifndef NTFS_RUNLIST_DECODER_UNIT_MACROS_SVH
`define NTFS_RUNLIST_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTFS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ntfs runlist decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NTFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ntfs runlist decoder: next-cycle check failed");

`endif

// ===== design/ntfs_rld_pkg.sv =====
package ntfs_rld_pkg;

	localparam int unsigned MAX_FIELD_BYTES = 4;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_OFFSET = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	localparam logic [1:0] KIND_RUN     = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] run_length;
		logic [63:0] run_cluster;
		logic [15:0] bytes_consumed;
	} result_t;

	// Sign-extends a little-endian offset from its own byte count.
	function automatic logic [63:0] extend_offset(input logic [31:0] raw,
			input logic [2:0] nbytes);
		logic [63:0] v;
		v = {32'd0, raw};
		case (nbytes)
			3'd1: begin
				if (raw[7])
					v = v | 64'hFFFF_FFFF_FFFF_FF00;
			end
			3'd2: begin
				if (raw[15])
					v = v | 64'hFFFF_FFFF_FFFF_0000;
			end
			3'd3: begin
				if (raw[23])
					v = v | 64'hFFFF_FFFF_FF00_0000;
			end
			3'd4: begin
				if (raw[31])
					v = v | 64'hFFFF_FFFF_0000_0000;
			end
			default: begin
				v = {32'd0, raw};
			end
		endcase
		return v;
	endfunction

endpackage

// ===== design/ntfs_runlist_decoder_unit.sv =====
// Run-list decoder. Bytes of a run list enter on the item channel
// (data_byte, start_of_list, item_valid, item_stall); a beat with
// start_of_list high loads the running cluster from base_cluster and
// restarts decoding with that byte as a header. Each completed run gives one
// result beat on the result channel (kind, run_length, run_cluster,
// bytes_consumed, result_valid, result_stall); a zero header gives one end
// beat and an invalid header one invalid beat, after which bytes are dropped
// until the next start flag. base_cluster is written through cfg_valid/cfg_ready,
// which is always ready, and takes effect at the next start flag.
// An accepted byte's result beat is registered. One byte is accepted every
// cycle while item_stall is low; the header decode, byte merge and 64-bit
// cluster add all sit between the state registers and the result register.
// When the receiver stalls, the result register holds its beat and a single
// skid register catches one more result; item_stall rises only while that
// skid register is full. Reset clears the decoder state, the base cluster
// and the valid flags of both result registers; bytes arriving before any
// start flag decode against a running cluster of zero.
module ntfs_runlist_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] base_cluster,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_list,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [31:0] run_length,
	output logic [63:0] run_cluster,
	output logic [15:0] bytes_consumed
);

	ntfs_rld_pkg::phase_t phase_q, phase_d, phase_eff;
	logic [2:0]  len_left_q, len_left_d;
	logic [2:0]  off_total_q, off_total_d;
	logic [2:0]  off_left_q, off_left_d;
	logic [1:0]  slot_q, slot_d;
	logic [31:0] len_acc_q, len_acc_d;
	logic [31:0] off_acc_q, off_acc_d;
	logic [63:0] cluster_q, cluster_d, cluster_eff;
	logic [15:0] count_q, count_d, count_eff, count_inc;
	logic [63:0] base_q;

	ntfs_rld_pkg::result_t res, out_q, skid_q;
	logic        res_v;
	logic        out_valid_q, skid_valid_q;
	logic        accept, out_free;

	logic [3:0]  len_nib, off_nib;
	logic        bad_header;
	logic [31:0] lane_byte;
	logic [2:0]  len_left_dec, off_left_dec;
	logic [31:0] off_merged;

	assign cfg_ready  = 1'b1;
	assign item_stall = skid_valid_q;
	assign accept     = item_valid && !skid_valid_q;
	assign out_free   = !out_valid_q || !result_stall;

	assign phase_eff   = start_of_list ? ntfs_rld_pkg::PH_HEADER : phase_q;
	assign cluster_eff = start_of_list ? base_q : cluster_q;
	assign count_eff   = start_of_list ? 16'd0 : count_q;
	assign count_inc   = (count_eff == 16'hFFFF) ? count_eff : count_eff + 16'd1;

	assign len_nib    = data_byte[3:0];
	assign off_nib    = data_byte[7:4];
	assign bad_header = (len_nib == 4'd0) || (len_nib > 4'(ntfs_rld_pkg::MAX_FIELD_BYTES)) ||
		(off_nib == 4'd0) || (off_nib > 4'(ntfs_rld_pkg::MAX_FIELD_BYTES));

	assign lane_byte    = {24'd0, data_byte} << {slot_q, 3'b000};
	assign len_left_dec = len_left_q - 3'd1;
	assign off_left_dec = off_left_q - 3'd1;
	assign off_merged   = off_acc_q | lane_byte;

	always_comb begin
		phase_d     = phase_eff;
		len_left_d  = len_left_q;
		off_total_d = off_total_q;
		off_left_d  = off_left_q;
		slot_d      = slot_q;
		len_acc_d   = len_acc_q;
		off_acc_d   = off_acc_q;
		cluster_d   = cluster_eff;
		count_d     = count_eff;
		res_v       = 1'b0;
		res.kind           = ntfs_rld_pkg::KIND_RUN;
		res.run_length     = 32'd0;
		res.run_cluster    = cluster_eff;
		res.bytes_consumed = count_eff;
		case (phase_eff)
			ntfs_rld_pkg::PH_HEADER: begin
				if (data_byte == 8'd0) begin
					res_v    = 1'b1;
					res.kind = ntfs_rld_pkg::KIND_END;
					phase_d  = ntfs_rld_pkg::PH_DONE;
				end else if (bad_header) begin
					res_v    = 1'b1;
					res.kind = ntfs_rld_pkg::KIND_INVALID;
					phase_d  = ntfs_rld_pkg::PH_DONE;
				end else begin
					count_d     = count_inc;
					len_left_d  = len_nib[2:0];
					off_total_d = off_nib[2:0];
					off_left_d  = off_nib[2:0];
					slot_d      = 2'd0;
					len_acc_d   = 32'd0;
					off_acc_d   = 32'd0;
					phase_d     = ntfs_rld_pkg::PH_LENGTH;
				end
			end
			ntfs_rld_pkg::PH_LENGTH: begin
				count_d    = count_inc;
				len_acc_d  = len_acc_q | lane_byte;
				slot_d     = slot_q + 2'd1;
				len_left_d = len_left_dec;
				if (len_left_dec == 3'd0) begin
					slot_d  = 2'd0;
					phase_d = ntfs_rld_pkg::PH_OFFSET;
				end
			end
			ntfs_rld_pkg::PH_OFFSET: begin
				count_d    = count_inc;
				off_acc_d  = off_merged;
				slot_d     = slot_q + 2'd1;
				off_left_d = off_left_dec;
				if (off_left_dec == 3'd0) begin
					cluster_d = cluster_eff +
						ntfs_rld_pkg::extend_offset(off_merged, off_total_q);
					res_v              = 1'b1;
					res.kind           = ntfs_rld_pkg::KIND_RUN;
					res.run_length     = len_acc_q;
					res.run_cluster    = cluster_d;
					res.bytes_consumed = count_inc;
					slot_d             = 2'd0;
					phase_d            = ntfs_rld_pkg::PH_HEADER;
				end
			end
			default: begin
				phase_d = ntfs_rld_pkg::PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= base_cluster;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ntfs_rld_pkg::PH_HEADER;
			len_left_q  <= 3'd0;
			off_total_q <= 3'd0;
			off_left_q  <= 3'd0;
			slot_q      <= 2'd0;
			len_acc_q   <= 32'd0;
			off_acc_q   <= 32'd0;
			cluster_q   <= 64'd0;
			count_q     <= 16'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			len_left_q  <= len_left_d;
			off_total_q <= off_total_d;
			off_left_q  <= off_left_d;
			slot_q      <= slot_d;
			len_acc_q   <= len_acc_d;
			off_acc_q   <= off_acc_d;
			cluster_q   <= cluster_d;
			count_q     <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && res_v;
			end
		end else if (accept && res_v) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= res;
			end
		end else if (accept && res_v) begin
			skid_q <= res;
		end
	end

	assign result_valid   = out_valid_q;
	assign kind           = out_q.kind;
	assign run_length     = out_q.run_length;
	assign run_cluster    = out_q.run_cluster;
	assign bytes_consumed = out_q.bytes_consumed;

endmodule

// ===== design/ntfs_rld_checker.sv =====
`include "ntfs_runlist_decoder_unit_macros.svh"

module ntfs_rld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic [7:0]  data_byte,
	input logic        start_of_list,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  kind,
	input logic [31:0] run_length,
	input logic [63:0] run_cluster,
	input logic [15:0] bytes_consumed
);

	`NTFS_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(kind) && $stable(run_length) && $stable(run_cluster) && $stable(bytes_consumed))

	`NTFS_ASSERT_SAME(a_end_has_no_length, result_valid && kind != ntfs_rld_pkg::KIND_RUN, run_length == 32'd0)

	`NTFS_ASSERT_NEXT(a_empty_list_ends, item_valid && !item_stall && start_of_list && data_byte == 8'd0 && !result_valid, result_valid && kind == ntfs_rld_pkg::KIND_END && bytes_consumed == 16'd0)

	`NTFS_ASSERT_NEXT(a_bad_first_header, item_valid && !item_stall && start_of_list && data_byte != 8'd0 && data_byte[3:0] == 4'd0 && !result_valid, result_valid && kind == ntfs_rld_pkg::KIND_INVALID && bytes_consumed == 16'd0)

endmodule

bind ntfs_runlist_decoder_unit ntfs_rld_checker u_ntfs_rld_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_stall     (item_stall),
	.data_byte      (data_byte),
	.start_of_list  (start_of_list),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.kind           (kind),
	.run_length     (run_length),
	.run_cluster    (run_cluster),
	.bytes_consumed (bytes_consumed)
);

// ===== test/tb_ntfs_runlist_decoder_unit.sv =====
`timescale 1ns / 100ps

module tb_ntfs_runlist_decoder_unit;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PER_PHASE = 90;

	typedef struct {
		logic [7:0] data;
		logic       sol;
	} list_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [63:0] base_cluster = 64'd0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        start_of_list = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic [31:0] run_length;
	logic [63:0] run_cluster;
	logic [15:0] bytes_consumed;

	list_byte_t            pending_bytes[$];
	ntfs_rld_pkg::result_t expected_results[$];
	list_byte_t            next_byte;
	ntfs_rld_pkg::result_t want;
	logic       item_taken = 1'b0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         holds_requested = 0;
	int         holds_granted = 0;
	int         hold_left = 0;
	int         cycle_count = 0;
	int         errors = 0;

	// Decoder state as the testbench tracks it.
	ntfs_rld_pkg::phase_t dec_phase = ntfs_rld_pkg::PH_HEADER;
	logic [2:0]  len_left = 3'd0;
	logic [2:0]  off_total = 3'd0;
	logic [2:0]  off_left = 3'd0;
	logic [1:0]  byte_pos = 2'd0;
	logic [31:0] len_acc = 32'd0;
	logic [31:0] off_acc = 32'd0;
	logic [63:0] cluster_now = 64'd0;
	logic [15:0] consumed = 16'd0;
	logic [63:0] base_reg = 64'd0;

	ntfs_runlist_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.base_cluster(base_cluster),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.data_byte(data_byte),
		.start_of_list(start_of_list),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.run_length(run_length),
		.run_cluster(run_cluster),
		.bytes_consumed(bytes_consumed)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic void note_result(input logic [1:0] k, input logic [31:0] len);
		ntfs_rld_pkg::result_t r;
		r.kind = k;
		r.run_length = len;
		r.run_cluster = cluster_now;
		r.bytes_consumed = consumed;
		expected_results.push_back(r);
	endfunction

	function automatic void count_byte();
		if (consumed != 16'hFFFF)
			consumed = consumed + 16'd1;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic sol);
		logic [63:0] delta;
		int          nbits;
		if (sol) begin
			cluster_now = base_reg;
			consumed = 16'd0;
			dec_phase = ntfs_rld_pkg::PH_HEADER;
			len_left = 3'd0;
			off_total = 3'd0;
			off_left = 3'd0;
			byte_pos = 2'd0;
			len_acc = 32'd0;
			off_acc = 32'd0;
		end
		case (dec_phase)
			ntfs_rld_pkg::PH_HEADER: begin
				if (b == 8'd0) begin
					note_result(ntfs_rld_pkg::KIND_END, 32'd0);
					dec_phase = ntfs_rld_pkg::PH_DONE;
				end else if (b[3:0] == 4'd0 || b[3:0] > ntfs_rld_pkg::MAX_FIELD_BYTES ||
						b[7:4] == 4'd0 || b[7:4] > ntfs_rld_pkg::MAX_FIELD_BYTES) begin
					note_result(ntfs_rld_pkg::KIND_INVALID, 32'd0);
					dec_phase = ntfs_rld_pkg::PH_DONE;
				end else begin
					count_byte();
					len_left = b[2:0];
					off_total = b[6:4];
					off_left = b[6:4];
					byte_pos = 2'd0;
					len_acc = 32'd0;
					off_acc = 32'd0;
					dec_phase = ntfs_rld_pkg::PH_LENGTH;
				end
			end
			ntfs_rld_pkg::PH_LENGTH: begin
				count_byte();
				len_acc = len_acc | ({24'd0, b} << (8 * byte_pos));
				byte_pos = byte_pos + 2'd1;
				len_left = len_left - 3'd1;
				if (len_left == 3'd0) begin
					byte_pos = 2'd0;
					dec_phase = ntfs_rld_pkg::PH_OFFSET;
				end
			end
			ntfs_rld_pkg::PH_OFFSET: begin
				count_byte();
				off_acc = off_acc | ({24'd0, b} << (8 * byte_pos));
				byte_pos = byte_pos + 2'd1;
				off_left = off_left - 3'd1;
				if (off_left == 3'd0) begin
					// The sign bit is the top bit of the last offset byte.
					nbits = 8 * int'(off_total);
					delta = {32'd0, off_acc};
					if (off_acc[nbits - 1])
						delta = delta | ({64{1'b1}} << nbits);
					cluster_now = cluster_now + delta;
					note_result(ntfs_rld_pkg::KIND_RUN, len_acc);
					byte_pos = 2'd0;
					dec_phase = ntfs_rld_pkg::PH_HEADER;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(negedge clk) begin
		if (!item_valid || item_taken) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_byte = pending_bytes.pop_front();
				item_valid <= 1'b1;
				data_byte <= next_byte.data;
				start_of_list <= next_byte.sol;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0)
			result_stall <= 1'b1;
		else
			result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_requested != holds_granted) begin
			hold_left <= HOLD_CYCLES;
			holds_granted <= holds_granted + 1;
		end
	end

	always @(posedge clk) begin
		item_taken = 1'b0;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				item_taken = 1'b1;
				decode_byte(data_byte, start_of_list);
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with none expected: kind %0d cluster %h", kind,
						run_cluster);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, kind);
						errors++;
					end
					if (run_length !== want.run_length) begin
						$error("run_length: expected %h, actual %h", want.run_length,
							run_length);
						errors++;
					end
					if (run_cluster !== want.run_cluster) begin
						$error("run_cluster: expected %h, actual %h", want.run_cluster,
							run_cluster);
						errors++;
					end
					if (bytes_consumed !== want.bytes_consumed) begin
						$error("bytes_consumed: expected %0d, actual %0d",
							want.bytes_consumed, bytes_consumed);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic sol);
		list_byte_t lb;
		lb.data = b;
		lb.sol = sol;
		pending_bytes.push_back(lb);
	endfunction

	task automatic write_base(input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		base_cluster <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		base_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_bytes.size() != 0 || item_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed lists with random content; some lists are cut off in
	// mid-run, some carry a random header, and some end on an invalid header.
	task automatic push_random_lists(input int target);
		int         taken;
		int         runs;
		int         ln;
		int         on;
		int         nbytes;
		int         ending;
		logic       first;
		logic       cut;
		logic [7:0] bad;
		taken = 0;
		while (taken < target) begin
			runs = $urandom_range(1, 5);
			first = 1'b1;
			cut = 1'b0;
			for (int r = 0; r < runs && !cut; r++) begin
				if ($urandom_range(19) == 0) begin
					push_byte(8'($urandom_range(255)), first);
					first = 1'b0;
					taken++;
				end
				ln = $urandom_range(1, 4);
				on = $urandom_range(1, 4);
				push_byte({on[3:0], ln[3:0]}, first);
				first = 1'b0;
				taken++;
				nbytes = ln + on;
				if ($urandom_range(15) == 0) begin
					nbytes = $urandom_range(0, ln + on - 1);
					cut = 1'b1;
				end
				for (int i = 0; i < nbytes; i++)
					push_byte(rand_byte(), 1'b0);
				taken += nbytes;
			end
			if (!cut) begin
				ending = $urandom_range(9);
				if (ending <= 6) begin
					push_byte(8'h00, 1'b0);
					taken++;
				end else if (ending <= 8) begin
					bad = 8'($urandom_range(255));
					while (bad[3:0] >= 4'd1 && bad[3:0] <= 4'd4 &&
							bad[7:4] >= 4'd1 && bad[7:4] <= 4'd4)
						bad = 8'($urandom_range(255));
					push_byte(bad, 1'b0);
					taken++;
				end
				if (ending <= 8) begin
					repeat ($urandom_range(0, 3))
						push_byte(8'($urandom_range(255)), 1'b0);
				end
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// The new base only applies from the next start flag on.
		write_base(64'hFFFF_FFFF_FFFF_FFFF);

		// A run before any start flag decodes against a cluster of zero.
		push_byte(8'h11, 1'b0);
		push_byte(8'h05, 1'b0);
		push_byte(8'h80, 1'b0);
		// Widest length and offset; the cluster wraps past the top.
		push_byte(8'h44, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		// Negative two-byte and three-byte offsets.
		push_byte(8'h21, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h31, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		// A start flag in mid-run drops the partial run.
		push_byte(8'h22, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h11, 1'b1);
		push_byte(8'h03, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h11, 1'b0);
		// Zero offset nibble, then an offset nibble above the maximum.
		push_byte(8'h01, 1'b1);
		push_byte(8'h51, 1'b1);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_base(64'd0);
		holds_requested = holds_requested + 1;
		push_random_lists(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 79;
		recv_stall_pct = 0;
		write_base(64'h8000_0000_0000_0000);
		push_random_lists(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 79;
		write_base({$urandom, $urandom});
		push_random_lists(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 15;
		recv_stall_pct = 15;
		write_base(64'h7FFF_FFFF_FFFF_FFFF);
		push_random_lists(RANDOM_PER_PHASE);
		wait_drained();

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
